FILE: hdl/assert_macros.svh
// Assertion macros used by the top level of the split work-stealing stack.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SWS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define SWS_NEVER(name, clk, rst, prop, msg) \
  `SWS_ASSERT(name, clk, rst, !(prop), msg)

`endif

FILE: hdl/sws_pkg.sv
// Types and constants of the split work-stealing stack.
package sws_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_CHUNK_DEF = 64;
  localparam int WORD_W        = 64;
  localparam int AMOUNT_W      = 7;
  localparam int COUNT_W       = 11;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1024;

  typedef enum logic [2:0] {
    MODE_PUSH    = 3'd0,
    MODE_PEEK    = 3'd1,
    MODE_POP     = 3'd2,
    MODE_RELEASE = 3'd3,
    MODE_ACQUIRE = 3'd4,
    MODE_STEAL   = 3'd5,
    MODE_CLEAR   = 3'd6,
    MODE_NOP     = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_SHORT    = 2'd3
  } status_t;

  typedef struct packed {
    mode_t                mode;
    logic [WORD_W-1:0]    entry_in;
    logic [AMOUNT_W-1:0]  amount;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0]    entry_out;
    status_t              status;
    logic [AMOUNT_W-1:0]  granted;
    logic [COUNT_W-1:0]   local_depth;
    logic [COUNT_W-1:0]   shared_avail;
    logic [COUNT_W-1:0]   peak_depth;
    logic                 last;
  } result_t;

endpackage

FILE: hdl/sws_ram.sv
// Single-port entry memory with registered read data.
module sws_ram #(
  parameter int DEPTH = sws_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic                        re,
  input  logic [AW-1:0]               addr,
  input  logic [sws_pkg::WORD_W-1:0]  wdata,
  output logic [sws_pkg::WORD_W-1:0]  rdata
);

  logic [sws_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: hdl/sws_ctrl.sv
// Boundary registers, operation decode and steal sequencer of the stack.
module sws_ctrl #(
  parameter int DEPTH     = sws_pkg::DEPTH_DEF,
  parameter int MAX_CHUNK = sws_pkg::MAX_CHUNK_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int PW = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  sws_pkg::cmd_t                 cmd,
  input  logic                          limit_we,
  input  logic [sws_pkg::COUNT_W-1:0]   limit_data,
  input  logic [sws_pkg::WORD_W-1:0]    rd_data,
  output logic                          busy,
  output logic                          ram_we,
  output logic                          ram_re,
  output logic [AW-1:0]                 ram_addr,
  output logic [sws_pkg::WORD_W-1:0]    ram_wdata,
  output sws_pkg::result_t              result,
  output logic                          strobe
);

  localparam int CW = (PW > sws_pkg::AMOUNT_W) ? PW : sws_pkg::AMOUNT_W;
  localparam int LW = (PW > sws_pkg::COUNT_W) ? PW : sws_pkg::COUNT_W;

  typedef enum logic {S_IDLE, S_STEAL} state_t;

  state_t                          state, state_next;
  logic [PW-1:0]                   top_idx, top_idx_next;
  logic [PW-1:0]                   local_start, local_start_next;
  logic [PW-1:0]                   shared_start, shared_start_next;
  logic [PW-1:0]                   peak_top, peak_top_next;
  logic [sws_pkg::COUNT_W-1:0]     stack_limit;
  logic [PW-1:0]                   steal_addr, steal_addr_next;
  logic [sws_pkg::AMOUNT_W-1:0]    steal_left, steal_left_next;
  logic [sws_pkg::AMOUNT_W-1:0]    steal_k, steal_k_next;
  logic                            strobe_next;
  logic                            from_mem, from_mem_next;
  sws_pkg::status_t                res_status, res_status_next;
  logic [sws_pkg::AMOUNT_W-1:0]    res_granted, res_granted_next;
  logic                            res_last, res_last_next;

  logic                            accept;
  logic [PW-1:0]                   local_depth, shared_avail, top_inc, top_dec;
  logic [LW-1:0]                   limit_eff;
  logic [CW-1:0]                   k_ext;
  logic                            full, empty, chunk_bad;

  assign accept       = start && (state == S_IDLE);
  assign busy         = (state != S_IDLE);
  assign local_depth  = top_idx - local_start;
  assign shared_avail = local_start - shared_start;
  assign top_inc      = top_idx + PW'(1);
  assign top_dec      = top_idx - PW'(1);
  assign limit_eff    = (LW'(stack_limit) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(stack_limit);
  assign full         = LW'(top_idx) >= limit_eff;
  assign empty        = top_idx <= local_start;
  assign k_ext        = CW'(cmd.amount);
  assign chunk_bad    = cmd.amount > sws_pkg::AMOUNT_W'(MAX_CHUNK);
  assign ram_wdata    = cmd.entry_in;

  always_comb begin
    state_next        = state;
    top_idx_next      = top_idx;
    local_start_next  = local_start;
    shared_start_next = shared_start;
    peak_top_next     = peak_top;
    steal_addr_next   = steal_addr;
    steal_left_next   = steal_left;
    steal_k_next      = steal_k;
    strobe_next       = 1'b0;
    from_mem_next     = 1'b0;
    res_status_next   = sws_pkg::ST_OK;
    res_granted_next  = '0;
    res_last_next     = 1'b1;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    ram_addr          = top_idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          case (cmd.mode)
            sws_pkg::MODE_PUSH: begin
              if (full) begin
                res_status_next = sws_pkg::ST_OVERFLOW;
              end else begin
                ram_we       = 1'b1;
                top_idx_next = top_inc;
                if (top_inc > peak_top) begin
                  peak_top_next = top_inc;
                end
              end
            end
            sws_pkg::MODE_PEEK: begin
              if (empty) begin
                res_status_next = sws_pkg::ST_EMPTY;
              end else begin
                ram_re        = 1'b1;
                ram_addr      = top_dec[AW-1:0];
                from_mem_next = 1'b1;
              end
            end
            sws_pkg::MODE_POP: begin
              if (empty) begin
                res_status_next = sws_pkg::ST_EMPTY;
              end else begin
                top_idx_next = top_dec;
              end
            end
            sws_pkg::MODE_RELEASE: begin
              if (chunk_bad || (k_ext > CW'(local_depth))) begin
                res_status_next = sws_pkg::ST_SHORT;
              end else begin
                local_start_next = local_start + PW'(cmd.amount);
              end
            end
            sws_pkg::MODE_ACQUIRE: begin
              if (chunk_bad || (k_ext > CW'(shared_avail))) begin
                res_status_next = sws_pkg::ST_SHORT;
              end else begin
                local_start_next = local_start - PW'(cmd.amount);
              end
            end
            sws_pkg::MODE_STEAL: begin
              if ((cmd.amount == '0) || chunk_bad || (k_ext > CW'(shared_avail))) begin
                res_status_next = sws_pkg::ST_SHORT;
              end else begin
                ram_re            = 1'b1;
                ram_addr          = shared_start[AW-1:0];
                from_mem_next     = 1'b1;
                shared_start_next = shared_start + PW'(cmd.amount);
                res_granted_next  = cmd.amount;
                res_last_next     = (cmd.amount == sws_pkg::AMOUNT_W'(1));
                steal_addr_next   = shared_start + PW'(1);
                steal_left_next   = cmd.amount - sws_pkg::AMOUNT_W'(1);
                steal_k_next      = cmd.amount;
                if (cmd.amount != sws_pkg::AMOUNT_W'(1)) begin
                  state_next = S_STEAL;
                end
              end
            end
            sws_pkg::MODE_CLEAR: begin
              top_idx_next      = '0;
              local_start_next  = '0;
              shared_start_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_STEAL: begin
        ram_re           = 1'b1;
        ram_addr         = steal_addr[AW-1:0];
        from_mem_next    = 1'b1;
        strobe_next      = 1'b1;
        res_granted_next = steal_k;
        res_last_next    = (steal_left == sws_pkg::AMOUNT_W'(1));
        steal_addr_next  = steal_addr + PW'(1);
        steal_left_next  = steal_left - sws_pkg::AMOUNT_W'(1);
        if (steal_left == sws_pkg::AMOUNT_W'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      top_idx      <= '0;
      local_start  <= '0;
      shared_start <= '0;
      peak_top     <= '0;
      stack_limit  <= sws_pkg::LIMIT_RESET;
      strobe       <= 1'b0;
    end else begin
      state        <= state_next;
      top_idx      <= top_idx_next;
      local_start  <= local_start_next;
      shared_start <= shared_start_next;
      peak_top     <= peak_top_next;
      strobe       <= strobe_next;
      if (limit_we) begin
        stack_limit <= limit_data;
      end
    end
    steal_addr  <= steal_addr_next;
    steal_left  <= steal_left_next;
    steal_k     <= steal_k_next;
    from_mem    <= from_mem_next;
    res_status  <= res_status_next;
    res_granted <= res_granted_next;
    res_last    <= res_last_next;
  end

  always_comb begin
    result.entry_out    = from_mem ? rd_data : '0;
    result.status       = res_status;
    result.granted      = res_granted;
    result.local_depth  = sws_pkg::COUNT_W'(local_depth);
    result.shared_avail = sws_pkg::COUNT_W'(shared_avail);
    result.peak_depth   = sws_pkg::COUNT_W'(peak_top);
    result.last         = res_last;
  end

endmodule

FILE: hdl/split_work_stealing_stack.sv
// Top level of the split work-stealing stack.
// Every operation except a granted steal returns its one result word in the cycle after it is
// accepted, and a new operation may be accepted in every such cycle. A granted steal of k
// entries returns k words on consecutive cycles, one per read of the single memory port, and
// holds busy high while it issues the reads of its remaining words. Results are strobed for one
// cycle and cannot be held off. The entry memory is not cleared at reset; the stack limit register
// may be written at any time the block is idle.
module split_work_stealing_stack #(
  parameter int DEPTH     = sws_pkg::DEPTH_DEF,
  parameter int MAX_CHUNK = sws_pkg::MAX_CHUNK_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  sws_pkg::cmd_t                 cmd,
  input  logic                          limit_we,
  input  logic [sws_pkg::COUNT_W-1:0]   limit_data,
  output sws_pkg::result_t              result,
  output logic                          strobe
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(DEPTH);

  logic                          ram_we;
  logic                          ram_re;
  logic [AW-1:0]                 ram_addr;
  logic [sws_pkg::WORD_W-1:0]    ram_wdata;
  logic [sws_pkg::WORD_W-1:0]    ram_rdata;
  logic                          bad_word;
  logic                          bad_grant;

  sws_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  sws_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_CHUNK (MAX_CHUNK)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .limit_we   (limit_we),
    .limit_data (limit_data),
    .rd_data    (ram_rdata),
    .busy       (busy),
    .ram_we     (ram_we),
    .ram_re     (ram_re),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .result     (result),
    .strobe     (strobe)
  );

  assign bad_word  = strobe && (result.status != sws_pkg::ST_OK) && (result.entry_out != 64'd0);
  assign bad_grant = strobe && (result.granted != 7'd0) && (result.status != sws_pkg::ST_OK);

  `SWS_ASSERT(a_busy_streams, clk, rst, busy |=> strobe, "steal stream dropped a word")
  `SWS_ASSERT(a_more_is_busy, clk, rst, (strobe && !result.last) |-> busy, "steal ended early")
  `SWS_NEVER(a_fail_no_word, clk, rst, bad_word, "failed operation returned a word")
  `SWS_NEVER(a_grant_ok, clk, rst, bad_grant, "grant with error status")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the split work-stealing stack: directed table, random runs, big fill.
`timescale 1ns / 100ps

module testbench;
  import sws_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int MAX_CHUNK = MAX_CHUNK_DEF;
  localparam int STALL_LIMIT = 400;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    mode_t               mode;
    logic [WORD_W-1:0]   word;
    logic [AMOUNT_W-1:0] amount;
    logic                typed;
    result_t             want;
  } plan_row_t;

  localparam result_t NO_WANT = '{64'h0, ST_OK, 7'd0, 11'd0, 11'd0, 11'd0, 1'b0};

  localparam plan_row_t PLAN [0:25] = '{
    '{MODE_PEEK, 64'h0, 7'd0, 1'b1, '{64'h0, ST_EMPTY, 7'd0, 11'd0, 11'd0, 11'd0, 1'b1}},
    '{MODE_POP, 64'h0, 7'd0, 1'b1, '{64'h0, ST_EMPTY, 7'd0, 11'd0, 11'd0, 11'd0, 1'b1}},
    '{MODE_RELEASE, 64'h0, 7'd0, 1'b1, '{64'h0, ST_OK, 7'd0, 11'd0, 11'd0, 11'd0, 1'b1}},
    '{MODE_ACQUIRE, 64'h0, 7'd0, 1'b1, '{64'h0, ST_OK, 7'd0, 11'd0, 11'd0, 11'd0, 1'b1}},
    '{MODE_STEAL, 64'h0, 7'd0, 1'b1, '{64'h0, ST_SHORT, 7'd0, 11'd0, 11'd0, 11'd0, 1'b1}},
    '{MODE_STEAL, 64'h0, 7'd1, 1'b1, '{64'h0, ST_SHORT, 7'd0, 11'd0, 11'd0, 11'd0, 1'b1}},
    '{MODE_RELEASE, 64'h0, 7'd65, 1'b1, '{64'h0, ST_SHORT, 7'd0, 11'd0, 11'd0, 11'd0, 1'b1}},
    '{MODE_ACQUIRE, 64'h0, 7'd127, 1'b1, '{64'h0, ST_SHORT, 7'd0, 11'd0, 11'd0, 11'd0, 1'b1}},
    '{MODE_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 1'b1,
      '{64'h0, ST_OK, 7'd0, 11'd1, 11'd0, 11'd1, 1'b1}},
    '{MODE_PUSH, 64'h0, 7'd0, 1'b1, '{64'h0, ST_OK, 7'd0, 11'd2, 11'd0, 11'd2, 1'b1}},
    '{MODE_PUSH, 64'h8000_0000_0000_0001, 7'd0, 1'b1,
      '{64'h0, ST_OK, 7'd0, 11'd3, 11'd0, 11'd3, 1'b1}},
    '{MODE_PEEK, 64'h0, 7'd0, 1'b1,
      '{64'h8000_0000_0000_0001, ST_OK, 7'd0, 11'd3, 11'd0, 11'd3, 1'b1}},
    '{MODE_POP, 64'h0, 7'd0, 1'b1, '{64'h0, ST_OK, 7'd0, 11'd2, 11'd0, 11'd3, 1'b1}},
    '{MODE_RELEASE, 64'h0, 7'd3, 1'b1, '{64'h0, ST_SHORT, 7'd0, 11'd2, 11'd0, 11'd3, 1'b1}},
    '{MODE_RELEASE, 64'h0, 7'd2, 1'b1, '{64'h0, ST_OK, 7'd0, 11'd0, 11'd2, 11'd3, 1'b1}},
    '{MODE_PEEK, 64'h0, 7'd0, 1'b1, '{64'h0, ST_EMPTY, 7'd0, 11'd0, 11'd2, 11'd3, 1'b1}},
    '{MODE_STEAL, 64'h0, 7'd3, 1'b1, '{64'h0, ST_SHORT, 7'd0, 11'd0, 11'd2, 11'd3, 1'b1}},
    '{MODE_ACQUIRE, 64'h0, 7'd1, 1'b1, '{64'h0, ST_OK, 7'd0, 11'd1, 11'd1, 11'd3, 1'b1}},
    '{MODE_STEAL, 64'h0, 7'd1, 1'b1,
      '{64'hFFFF_FFFF_FFFF_FFFF, ST_OK, 7'd1, 11'd1, 11'd0, 11'd3, 1'b1}},
    '{MODE_NOP, 64'h0, 7'd127, 1'b1, '{64'h0, ST_OK, 7'd0, 11'd1, 11'd0, 11'd3, 1'b1}},
    '{MODE_CLEAR, 64'h0, 7'd0, 1'b1, '{64'h0, ST_OK, 7'd0, 11'd0, 11'd0, 11'd3, 1'b1}},
    '{MODE_PUSH, 64'h0123_4567_89AB_CDEF, 7'd0, 1'b0, NO_WANT},
    '{MODE_PUSH, 64'hFEDC_BA98_7654_3210, 7'd0, 1'b0, NO_WANT},
    '{MODE_PUSH, 64'h5A5A_A5A5_3C3C_C3C3, 7'd0, 1'b0, NO_WANT},
    '{MODE_RELEASE, 64'h0, 7'd3, 1'b0, NO_WANT},
    '{MODE_STEAL, 64'h0, 7'd3, 1'b0, NO_WANT}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '{MODE_NOP, 64'h0, 7'd0};
  logic limit_we = 1'b0;
  logic [COUNT_W-1:0] limit_data = '0;
  result_t result;
  logic strobe;

  split_work_stealing_stack DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .limit_we(limit_we),
    .limit_data(limit_data),
    .result(result),
    .strobe(strobe)
  );

  always #5 clk = ~clk;

  logic [WORD_W-1:0] words [0:DEPTH-1];
  int top_i = 0;
  int lo_i = 0;
  int sh_i = 0;
  int peak_i = 0;
  int limit_r = 1024;
  result_t results_owed [$];
  result_t want_word;
  int mismatches = 0;
  int idle_cycles = 0;
  int quiet = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
    end
    mismatches++;
  endtask

  task automatic owe(logic [WORD_W-1:0] w, status_t st, int granted, bit last);
    result_t r;
    r.entry_out = w;
    r.status = st;
    r.granted = granted[AMOUNT_W-1:0];
    r.local_depth = COUNT_W'(top_i - lo_i);
    r.shared_avail = COUNT_W'(lo_i - sh_i);
    r.peak_depth = COUNT_W'(peak_i);
    r.last = last;
    results_owed.push_back(r);
  endtask

  task automatic stack_apply(cmd_t c);
    int k;
    int ld;
    int sa;
    int cap;
    int base;
    k = int'(c.amount);
    ld = top_i - lo_i;
    sa = lo_i - sh_i;
    cap = (limit_r > DEPTH) ? DEPTH : limit_r;
    case (c.mode)
      MODE_PUSH: begin
        if (top_i >= cap) begin
          owe('0, ST_OVERFLOW, 0, 1'b1);
        end else begin
          words[top_i] = c.entry_in;
          top_i++;
          if (top_i > peak_i) peak_i = top_i;
          owe('0, ST_OK, 0, 1'b1);
        end
      end
      MODE_PEEK: begin
        if (ld <= 0) owe('0, ST_EMPTY, 0, 1'b1);
        else owe(words[top_i-1], ST_OK, 0, 1'b1);
      end
      MODE_POP: begin
        if (ld <= 0) begin
          owe('0, ST_EMPTY, 0, 1'b1);
        end else begin
          top_i--;
          owe('0, ST_OK, 0, 1'b1);
        end
      end
      MODE_RELEASE: begin
        if (k > MAX_CHUNK || k > ld) begin
          owe('0, ST_SHORT, 0, 1'b1);
        end else begin
          lo_i += k;
          owe('0, ST_OK, 0, 1'b1);
        end
      end
      MODE_ACQUIRE: begin
        if (k > MAX_CHUNK || k > sa) begin
          owe('0, ST_SHORT, 0, 1'b1);
        end else begin
          lo_i -= k;
          owe('0, ST_OK, 0, 1'b1);
        end
      end
      MODE_STEAL: begin
        if (k == 0 || k > MAX_CHUNK || k > sa) begin
          owe('0, ST_SHORT, 0, 1'b1);
        end else begin
          base = sh_i;
          sh_i += k;
          for (int i = 0; i < k; i++) begin
            owe(words[base+i], ST_OK, k, i == k - 1);
          end
        end
      end
      MODE_CLEAR: begin
        top_i = 0;
        lo_i = 0;
        sh_i = 0;
        owe('0, ST_OK, 0, 1'b1);
      end
      default: owe('0, ST_OK, 0, 1'b1);
    endcase
  endtask

  function automatic cmd_t op(mode_t m, logic [WORD_W-1:0] w, logic [AMOUNT_W-1:0] k);
    cmd_t c;
    c.mode = m;
    c.entry_in = w;
    c.amount = k;
    return c;
  endfunction

  function automatic cmd_t next_cmd();
    int r;
    int ld;
    int sa;
    int k;
    mode_t m;
    ld = top_i - lo_i;
    sa = lo_i - sh_i;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 127);
    if (r < 34) begin
      m = MODE_PUSH;
    end else if (r < 42) begin
      m = MODE_PEEK;
    end else if (r < 52) begin
      m = MODE_POP;
    end else if (r < 64) begin
      m = MODE_RELEASE;
      if ($urandom_range(0, 4) != 0) k = $urandom_range(0, ld < MAX_CHUNK ? ld : MAX_CHUNK);
    end else if (r < 72) begin
      m = MODE_ACQUIRE;
      if ($urandom_range(0, 4) != 0) k = $urandom_range(0, sa < MAX_CHUNK ? sa : MAX_CHUNK);
    end else if (r < 88) begin
      m = MODE_STEAL;
      if ($urandom_range(0, 4) != 0) begin
        k = $urandom_range(1, sa < 1 ? 1 : (sa < MAX_CHUNK ? sa : MAX_CHUNK));
      end
    end else if (r < 91) begin
      m = MODE_CLEAR;
    end else if (r < 94) begin
      m = MODE_NOP;
    end else begin
      m = mode_t'($urandom_range(0, 7));
    end
    return op(m, {$urandom, $urandom}, k[AMOUNT_W-1:0]);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send(cmd_t c);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    stack_apply(c);
    @(negedge clk);
  endtask

  task automatic sender_pause();
    int gap;
    if (quiet > 0) begin
      quiet--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 30);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 18);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic set_limit(logic [COUNT_W-1:0] v);
    start <= 1'b0;
    while (results_owed.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    limit_we <= 1'b1;
    limit_data <= v;
    @(negedge clk);
    limit_we <= 1'b0;
    limit_r = int'(v);
  endtask

  task automatic run_random(int n);
    repeat (n) begin
      sender_pause();
      send(next_cmd());
    end
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (results_owed.size() == 0) begin
        report_mismatch("unexpected word", result.entry_out, 64'd0);
      end else begin
        want_word = results_owed.pop_front();
        if (result.entry_out !== want_word.entry_out)
          report_mismatch("entry_out", result.entry_out, want_word.entry_out);
        if (result.status !== want_word.status)
          report_mismatch("status", 64'(result.status), 64'(want_word.status));
        if (result.granted !== want_word.granted)
          report_mismatch("granted", 64'(result.granted), 64'(want_word.granted));
        if (result.local_depth !== want_word.local_depth)
          report_mismatch("local_depth", 64'(result.local_depth), 64'(want_word.local_depth));
        if (result.shared_avail !== want_word.shared_avail)
          report_mismatch("shared_avail", 64'(result.shared_avail),
                          64'(want_word.shared_avail));
        if (result.peak_depth !== want_word.peak_depth)
          report_mismatch("peak_depth", 64'(result.peak_depth), 64'(want_word.peak_depth));
        if (result.last !== want_word.last)
          report_mismatch("last", 64'(result.last), 64'(want_word.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[split_work_stealing_stack] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < $size(PLAN); i++) begin
      sender_pause();
      send(op(PLAN[i].mode, PLAN[i].word, PLAN[i].amount));
      if (PLAN[i].typed) begin
        void'(results_owed.pop_back());
        results_owed.push_back(PLAN[i].want);
      end
    end

    set_limit(11'd40);
    run_random(30);
    set_limit(11'd1);
    run_random(20);
    set_limit(11'd0);
    run_random(15);
    set_limit(11'd1024);
    run_random(35);
    set_limit(11'd5);
    run_random(20);
    set_limit(COUNT_W'($urandom_range(2, 200)));
    run_random(30);

    // Push 200 entries with the limit above the depth, then move full chunks.
    set_limit(11'h7FF);
    send(op(MODE_CLEAR, 64'h0, 7'd0));
    repeat (200) send(op(MODE_PUSH, {$urandom, $urandom}, 7'd0));
    send(op(MODE_PEEK, 64'h0, 7'd0));
    repeat (3) send(op(MODE_RELEASE, 64'h0, 7'(MAX_CHUNK)));
    send(op(MODE_STEAL, 64'h0, 7'(MAX_CHUNK)));
    send(op(MODE_ACQUIRE, 64'h0, 7'(MAX_CHUNK)));
    repeat (2) send(op(MODE_STEAL, 64'h0, 7'(MAX_CHUNK)));
    run_random(15);

    start <= 1'b0;
    while (results_owed.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("[split_work_stealing_stack] OK");
    end else begin
      $display("[split_work_stealing_stack] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/sws_pkg.sv
hdl/sws_ram.sv
hdl/sws_ctrl.sv
hdl/split_work_stealing_stack.sv
tb/testbench.sv
